// ===== hw/rtl/glob_pattern_matcher_assert.svh =====
// Assertion macros used by the glob pattern matcher back end
`ifndef GLOB_PATTERN_MATCHER_ASSERT_SVH
`define GLOB_PATTERN_MATCHER_ASSERT_SVH

// check a condition on every rising clock edge out of reset
`define GPM_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("gpm assertion failed");

// check a consequence in the same cycle
`define GPM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gpm assertion failed");

// check a consequence in the next cycle
`define GPM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gpm assertion failed");

`endif

// ===== hw/rtl/gpm_pkg.sv =====
// Package with types, codes and constants of the glob pattern matcher
package gpm_pkg;

  localparam int PATTERN_MAX_DEF = 32;
  localparam int SET_MAX_DEF     = 8;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [1:0] KIND_PBYTE = 2'd0;
  localparam logic [1:0] KIND_PEND  = 2'd1;
  localparam logic [1:0] KIND_TBYTE = 2'd2;
  localparam logic [1:0] KIND_TEND  = 2'd3;

  localparam logic [1:0] IK_LIT  = 2'd0;
  localparam logic [1:0] IK_ANY  = 2'd1;
  localparam logic [1:0] IK_STAR = 2'd2;
  localparam logic [1:0] IK_SET  = 2'd3;

  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_CARET = 8'h5e;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_QUEST = 8'h3f;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_RBRK  = 8'h5d;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_DASH  = 8'h2d;

  typedef enum logic [1:0] {
    OP_PBYTE,
    OP_COMPILE,
    OP_TEXT,
    OP_TEND
  } op_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
  } in_item_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } out_item_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
  } q_entry_t;

endpackage

// ===== hw/rtl/gpm_front.sv =====
// Input front end: accepts transactions, decodes kind, drops zero bytes
module gpm_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  gpm_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              push_valid,
  output gpm_pkg::q_entry_t push_data
);

  logic drop;

  always_comb begin
    push_data.ch = in_data.ch;
    drop         = 1'b0;
    case (in_data.kind)
      gpm_pkg::KIND_PBYTE: begin
        push_data.op = gpm_pkg::OP_PBYTE;
        drop         = (in_data.ch == 8'd0);
      end
      gpm_pkg::KIND_PEND: begin
        push_data.op = gpm_pkg::OP_COMPILE;
      end
      gpm_pkg::KIND_TBYTE: begin
        push_data.op = gpm_pkg::OP_TEXT;
        drop         = (in_data.ch == 8'd0);
      end
      default: begin
        push_data.op = gpm_pkg::OP_TEND;
      end
    endcase
  end

  assign in_ready   = !q_full;
  assign push_valid = in_valid && !q_full && !drop;

endmodule

// ===== hw/rtl/gpm_fifo.sv =====
// Short command queue between front end and execution back end
module gpm_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  gpm_pkg::q_entry_t push_data,
  output logic              full,
  output logic              pop_valid,
  input  logic              pop_ready,
  output gpm_pkg::q_entry_t pop_data
);

  localparam int AW = (gpm_pkg::QUEUE_DEPTH > 1) ? $clog2(gpm_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(gpm_pkg::QUEUE_DEPTH + 1);

  gpm_pkg::q_entry_t ent_r [gpm_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign full      = (cnt_r == CW'(gpm_pkg::QUEUE_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = ent_r[rd_r];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop_valid && pop_ready;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == AW'(gpm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_r + AW'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == AW'(gpm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/gpm_back.sv =====
// Execution back end: pattern store, compile sequencer, position-set matcher
`include "glob_pattern_matcher_assert.svh"
module gpm_back #(
  parameter int PATTERN_MAX = gpm_pkg::PATTERN_MAX_DEF,
  parameter int SET_MAX     = gpm_pkg::SET_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  gpm_pkg::q_entry_t  q_data,
  output logic               out_valid,
  input  logic               out_ready,
  output gpm_pkg::out_item_t out_data
);

  localparam int PW = $clog2(PATTERN_MAX + 1);
  localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int MW = $clog2(SET_MAX + 2);
  localparam int SW = (SET_MAX > 1) ? $clog2(SET_MAX) : 1;
  localparam int AV = PATTERN_MAX + 1;

  typedef enum logic [3:0] {
    S_IDLE, C_ITEM, C_ESC, F_NEG, F_BRK, F_SCAN, B_NEG, B_LOW,
    B_LOWESC, B_DASH, B_HIGH, B_HIGHESC, S_FIN, S_SEED
  } state_t;

  state_t st_r, st_nxt;
  logic [7:0] mem [PATTERN_MAX];
  logic [7:0] rdata_r;
  logic [PW-1:0] len_r, len_nxt, ptr_r, ptr_nxt, k_r, k_nxt, cnt_r, cnt_nxt;
  logic [PW-1:0] orig_r, orig_nxt, close_r, close_nxt;
  logic [MW-1:0] m_r, m_nxt;
  logic [7:0] low_r, low_nxt;
  logic fresh_r, fresh_nxt, lovf_r, lovf_nxt, ovf_r, ovf_nxt;
  logic [AV-1:0] act_r, act_nxt;
  logic out_valid_r, out_valid_nxt;
  gpm_pkg::out_item_t out_data_r, out_data_nxt;

  logic [1:0] kind_r [PATTERN_MAX];
  logic [7:0] val_r [PATTERN_MAX];
  logic neg_r [PATTERN_MAX];
  logic [SET_MAX-1:0] rv_r [PATTERN_MAX];
  logic [7:0] lo_r [PATTERN_MAX][SET_MAX];
  logic [7:0] hi_r [PATTERN_MAX][SET_MAX];

  logic mem_we;
  logic [IW-1:0] mem_wa;
  logic item_we, set_init, neg_we, rng_we;
  logic [1:0] kind_w;
  logic [7:0] val_w, hi_w;
  logic pop;
  logic [PW:0] ptr_p1, len_e, close_e;
  logic [PW-1:0] base;
  logic [PATTERN_MAX-1:0] star_v, acc_v;
  logic [AV-1:0] s_ext, step_v, seed_fill, step_fill;
  logic [IW-1:0] k_idx;
  logic [SW-1:0] slot;

  assign k_idx   = k_r[IW-1:0];
  assign slot    = m_r[SW-1:0];
  assign ptr_p1  = {1'b0, ptr_r} + (PW+1)'(1);
  assign len_e   = {1'b0, len_r};
  assign close_e = {1'b0, close_r};
  assign base    = fresh_r ? '0 : len_r;

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      logic lane_on, hit;
      lane_on = (PW'(i) < cnt_r);
      hit = 1'b0;
      for (int j = 0; j < SET_MAX; j++) begin
        hit = hit | (rv_r[i][j] && (q_data.ch >= lo_r[i][j]) && (q_data.ch <= hi_r[i][j]));
      end
      star_v[i] = lane_on && (kind_r[i] == gpm_pkg::IK_STAR);
      case (kind_r[i])
        gpm_pkg::IK_ANY: acc_v[i] = lane_on;
        gpm_pkg::IK_LIT: acc_v[i] = lane_on && (val_r[i] == q_data.ch);
        gpm_pkg::IK_SET: acc_v[i] = lane_on && (hit ^ neg_r[i]);
        default:         acc_v[i] = 1'b0;
      endcase
    end
  end

  assign s_ext     = {1'b0, star_v};
  assign step_v    = (act_r & s_ext) | {acc_v & act_r[PATTERN_MAX-1:0], 1'b0};
  assign seed_fill = ((AV'(1) & s_ext) + s_ext) ^ s_ext;
  assign step_fill = ((step_v & s_ext) + s_ext) ^ s_ext;

  assign pop = (st_r == S_IDLE) && q_valid &&
               ((q_data.op != gpm_pkg::OP_TEND) || !out_valid_r || out_ready);
  assign q_ready = pop;

  always_comb begin
    st_nxt        = st_r;
    len_nxt       = len_r;
    ptr_nxt       = ptr_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    orig_nxt      = orig_r;
    close_nxt     = close_r;
    m_nxt         = m_r;
    low_nxt       = low_r;
    fresh_nxt     = fresh_r;
    lovf_nxt      = lovf_r;
    ovf_nxt       = ovf_r;
    act_nxt       = act_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_wa        = base[IW-1:0];
    item_we       = 1'b0;
    set_init      = 1'b0;
    neg_we        = 1'b0;
    rng_we        = 1'b0;
    kind_w        = gpm_pkg::IK_LIT;
    val_w         = rdata_r;
    hi_w          = rdata_r;
    case (st_r)
      S_IDLE: begin
        if (pop) begin
          case (q_data.op)
            gpm_pkg::OP_PBYTE: begin
              fresh_nxt = 1'b0;
              lovf_nxt  = fresh_r ? 1'b0 : lovf_r;
              if (base < PW'(PATTERN_MAX)) begin
                mem_we  = 1'b1;
                len_nxt = base + PW'(1);
              end else begin
                lovf_nxt = 1'b1;
              end
            end
            gpm_pkg::OP_COMPILE: begin
              ovf_nxt = lovf_r;
              k_nxt   = '0;
              ptr_nxt = '0;
              st_nxt  = C_ITEM;
            end
            gpm_pkg::OP_TEXT: begin
              act_nxt = step_v | step_fill;
            end
            default: begin
              out_valid_nxt                 = 1'b1;
              out_data_nxt.matched          = !ovf_r && act_r[cnt_r];
              out_data_nxt.pattern_overflow = ovf_r;
              act_nxt                       = AV'(1) | seed_fill;
            end
          endcase
        end
      end
      C_ITEM: begin
        if (ovf_r || ptr_r >= len_r || k_r >= PW'(PATTERN_MAX)) begin
          st_nxt = S_FIN;
        end else if (rdata_r == gpm_pkg::CH_STAR) begin
          item_we = 1'b1;
          kind_w  = gpm_pkg::IK_STAR;
          k_nxt   = k_r + PW'(1);
          ptr_nxt = ptr_p1[PW-1:0];
        end else if (rdata_r == gpm_pkg::CH_QUEST) begin
          item_we = 1'b1;
          kind_w  = gpm_pkg::IK_ANY;
          k_nxt   = k_r + PW'(1);
          ptr_nxt = ptr_p1[PW-1:0];
        end else if (rdata_r == gpm_pkg::CH_LBRK) begin
          orig_nxt = ptr_r;
          ptr_nxt  = ptr_p1[PW-1:0];
          st_nxt   = F_NEG;
        end else if (rdata_r == gpm_pkg::CH_BSL && ptr_p1 < len_e) begin
          ptr_nxt = ptr_p1[PW-1:0];
          st_nxt  = C_ESC;
        end else begin
          item_we = 1'b1;
          k_nxt   = k_r + PW'(1);
          ptr_nxt = ptr_p1[PW-1:0];
        end
      end
      C_ESC: begin
        item_we = 1'b1;
        k_nxt   = k_r + PW'(1);
        ptr_nxt = ptr_p1[PW-1:0];
        st_nxt  = C_ITEM;
      end
      F_NEG: begin
        if (ptr_r < len_r && (rdata_r == gpm_pkg::CH_BANG || rdata_r == gpm_pkg::CH_CARET)) begin
          ptr_nxt = ptr_p1[PW-1:0];
        end
        st_nxt = F_BRK;
      end
      F_BRK: begin
        if (ptr_r < len_r && rdata_r == gpm_pkg::CH_RBRK) begin
          ptr_nxt = ptr_p1[PW-1:0];
        end
        st_nxt = F_SCAN;
      end
      F_SCAN: begin
        if (ptr_r >= len_r) begin
          item_we = 1'b1;
          val_w   = gpm_pkg::CH_LBRK;
          k_nxt   = k_r + PW'(1);
          ptr_nxt = orig_r + PW'(1);
          st_nxt  = C_ITEM;
        end else if (rdata_r == gpm_pkg::CH_RBRK) begin
          item_we   = 1'b1;
          kind_w    = gpm_pkg::IK_SET;
          set_init  = 1'b1;
          m_nxt     = '0;
          close_nxt = ptr_r;
          ptr_nxt   = orig_r + PW'(1);
          st_nxt    = B_NEG;
        end else if (rdata_r == gpm_pkg::CH_BSL && ptr_p1 < len_e) begin
          ptr_nxt = ptr_r + PW'(2);
        end else begin
          ptr_nxt = ptr_p1[PW-1:0];
        end
      end
      B_NEG: begin
        if (rdata_r == gpm_pkg::CH_BANG || rdata_r == gpm_pkg::CH_CARET) begin
          neg_we  = 1'b1;
          ptr_nxt = ptr_p1[PW-1:0];
        end
        st_nxt = B_LOW;
      end
      B_LOW: begin
        if (ptr_r >= close_r) begin
          if (m_r > MW'(SET_MAX)) begin
            ovf_nxt = 1'b1;
          end
          k_nxt   = k_r + PW'(1);
          ptr_nxt = close_r + PW'(1);
          st_nxt  = C_ITEM;
        end else if (rdata_r == gpm_pkg::CH_BSL && ptr_p1 < close_e) begin
          ptr_nxt = ptr_p1[PW-1:0];
          st_nxt  = B_LOWESC;
        end else begin
          low_nxt = rdata_r;
          ptr_nxt = ptr_p1[PW-1:0];
          st_nxt  = B_DASH;
        end
      end
      B_LOWESC: begin
        low_nxt = rdata_r;
        ptr_nxt = ptr_p1[PW-1:0];
        st_nxt  = B_DASH;
      end
      B_DASH: begin
        if (ptr_p1 < close_e && rdata_r == gpm_pkg::CH_DASH) begin
          ptr_nxt = ptr_p1[PW-1:0];
          st_nxt  = B_HIGH;
        end else begin
          rng_we = 1'b1;
          hi_w   = low_r;
          st_nxt = B_LOW;
        end
      end
      B_HIGH: begin
        if (rdata_r == gpm_pkg::CH_BSL && ptr_p1 < close_e) begin
          ptr_nxt = ptr_p1[PW-1:0];
          st_nxt  = B_HIGHESC;
        end else begin
          rng_we  = 1'b1;
          ptr_nxt = ptr_p1[PW-1:0];
          st_nxt  = B_LOW;
        end
      end
      B_HIGHESC: begin
        rng_we  = 1'b1;
        ptr_nxt = ptr_p1[PW-1:0];
        st_nxt  = B_LOW;
      end
      S_FIN: begin
        cnt_nxt   = ovf_r ? '0 : k_r;
        fresh_nxt = 1'b1;
        st_nxt    = S_SEED;
      end
      S_SEED: begin
        act_nxt = AV'(1) | seed_fill;
        st_nxt  = S_IDLE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
    if (rng_we && m_r <= MW'(SET_MAX)) begin
      m_nxt = m_r + MW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      len_r       <= '0;
      ptr_r       <= '0;
      k_r         <= '0;
      cnt_r       <= '0;
      orig_r      <= '0;
      close_r     <= '0;
      m_r         <= '0;
      low_r       <= '0;
      fresh_r     <= 1'b1;
      lovf_r      <= 1'b0;
      ovf_r       <= 1'b0;
      act_r       <= AV'(1);
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      st_r        <= st_nxt;
      len_r       <= len_nxt;
      ptr_r       <= ptr_nxt;
      k_r         <= k_nxt;
      cnt_r       <= cnt_nxt;
      orig_r      <= orig_nxt;
      close_r     <= close_nxt;
      m_r         <= m_nxt;
      low_r       <= low_nxt;
      fresh_r     <= fresh_nxt;
      lovf_r      <= lovf_nxt;
      ovf_r       <= ovf_nxt;
      act_r       <= act_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= q_data.ch;
    end
    if (ptr_nxt < PW'(PATTERN_MAX)) begin
      rdata_r <= mem[ptr_nxt[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (item_we) begin
      kind_r[k_idx] <= kind_w;
      val_r[k_idx]  <= val_w;
    end
    if (set_init) begin
      rv_r[k_idx]  <= '0;
      neg_r[k_idx] <= 1'b0;
    end
    if (neg_we) begin
      neg_r[k_idx] <= 1'b1;
    end
    if (rng_we && m_r < MW'(SET_MAX)) begin
      lo_r[k_idx][slot]  <= low_r;
      hi_r[k_idx][slot]  <= hi_w;
      rv_r[k_idx][slot] <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `GPM_ASSERT_IMPL(a_ovf_empty, (st_r == S_IDLE) && ovf_r, cnt_r == '0)
  `GPM_ASSERT_IMPL(a_ovf_nomatch, out_valid_r && out_data_r.pattern_overflow, !out_data_r.matched)
  `GPM_ASSERT_ALWAYS(a_k_bound, k_r <= PW'(PATTERN_MAX))
  `GPM_ASSERT_NEXT(a_seed_start, st_r == S_SEED, act_r[0])

endmodule

// ===== hw/rtl/glob_pattern_matcher.sv =====
// Top level of the glob pattern matcher
//
//  channel  direction  payload                          handshake
//  in_      input      in_item_t  {kind, ch}            in_valid / in_ready
//  out_     output     out_item_t {matched, overflow}   out_valid / out_ready
//
// Pattern bytes, text bytes and text end are each taken by the back end in its idle state.
// Pattern end runs the compile sequencer, which scans the stored pattern and rescans
// each bracket set; it reads one stored byte a cycle.
// A two-entry queue decouples input from the back end; a waiting result blocks
// only the next text end. Reset is synchronous on rst_n and takes effect at once.
module glob_pattern_matcher #(
  parameter int PATTERN_MAX = gpm_pkg::PATTERN_MAX_DEF,
  parameter int SET_MAX     = gpm_pkg::SET_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  gpm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output gpm_pkg::out_item_t out_data
);

  logic              q_full, push_valid, pop_valid, pop_ready;
  gpm_pkg::q_entry_t push_data, pop_data;

  gpm_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  gpm_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (q_full),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  gpm_back #(
    .PATTERN_MAX (PATTERN_MAX),
    .SET_MAX     (SET_MAX)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (pop_valid),
    .q_ready   (pop_ready),
    .q_data    (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== bench/gpm_checker.sv =====
// Checker for the glob pattern matcher: tracks pattern and text state, predicts and compares
module gpm_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  gpm_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  gpm_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending
);

  localparam int PMAX = gpm_pkg::PATTERN_MAX_DEF;
  localparam logic [PMAX:0] START_POS = (PMAX+1)'(1);

  logic [7:0]   pat_buf [PMAX];
  int           pat_len;
  logic [1:0]   elem_kind [PMAX];
  logic [7:0]   elem_val [PMAX];
  logic [255:0] elem_set [PMAX];
  int           elem_cnt;
  logic [PMAX:0] live;
  logic         ovf;
  logic         load_ovf;
  logic         fresh;
  gpm_pkg::out_item_t verdicts[$];

  function automatic logic [PMAX:0] close_stars(logic [PMAX:0] a);
    for (int i = 0; i < elem_cnt; i++)
      if (a[i] && elem_kind[i] == gpm_pkg::IK_STAR) a[i+1] = 1'b1;
    return a;
  endfunction

  function automatic int close_index(int o, int len);
    int q;
    q = o + 1;
    if (q < len && (pat_buf[q] == gpm_pkg::CH_BANG || pat_buf[q] == gpm_pkg::CH_CARET)) q++;
    if (q < len && pat_buf[q] == gpm_pkg::CH_RBRK) q++;
    while (q < len && pat_buf[q] != gpm_pkg::CH_RBRK) begin
      if (pat_buf[q] == gpm_pkg::CH_BSL && q + 1 < len) q++;
      q++;
    end
    return q;
  endfunction

  function automatic void fill_set(int k, int o, int cl);
    int p, h, members;
    logic neg;
    logic [7:0] lo, hi;
    logic [255:0] m;
    p = o + 1;
    members = 0;
    neg = 1'b0;
    m = '0;
    if (pat_buf[p] == gpm_pkg::CH_BANG || pat_buf[p] == gpm_pkg::CH_CARET) begin
      neg = 1'b1;
      p++;
    end
    while (p < cl) begin
      lo = pat_buf[p];
      if (lo == gpm_pkg::CH_BSL && p + 1 < cl) begin
        p++;
        lo = pat_buf[p];
      end
      members++;
      if (p + 2 < cl && pat_buf[p+1] == gpm_pkg::CH_DASH) begin
        h = p + 2;
        hi = pat_buf[h];
        if (hi == gpm_pkg::CH_BSL && h + 1 < cl) begin
          h++;
          hi = pat_buf[h];
        end
        for (int b = lo; b <= hi; b++) m[b] = 1'b1;
        p = h + 1;
      end else begin
        m[lo] = 1'b1;
        p++;
      end
    end
    if (members > gpm_pkg::SET_MAX_DEF) ovf = 1'b1;
    elem_set[k] = neg ? ~m : m;
  endfunction

  function automatic void compile_items();
    int p, k, cl;
    logic [7:0] c;
    p = 0;
    k = 0;
    ovf = load_ovf;
    while (!ovf && p < pat_len && k < PMAX) begin
      c = pat_buf[p];
      if (c == gpm_pkg::CH_STAR) begin
        elem_kind[k] = gpm_pkg::IK_STAR;
        p++;
      end else if (c == gpm_pkg::CH_QUEST) begin
        elem_kind[k] = gpm_pkg::IK_ANY;
        p++;
      end else if (c == gpm_pkg::CH_LBRK && close_index(p, pat_len) < pat_len) begin
        cl = close_index(p, pat_len);
        elem_kind[k] = gpm_pkg::IK_SET;
        fill_set(k, p, cl);
        p = cl + 1;
      end else begin
        if (c == gpm_pkg::CH_BSL && p + 1 < pat_len) p++;
        elem_kind[k] = gpm_pkg::IK_LIT;
        elem_val[k] = pat_buf[p];
        p++;
      end
      k++;
    end
    elem_cnt = ovf ? 0 : k;
    live = close_stars(START_POS);
    fresh = 1'b1;
  endfunction

  function automatic void advance_text(logic [7:0] c);
    logic [PMAX:0] nxt;
    nxt = '0;
    for (int i = 0; i < elem_cnt; i++) begin
      if (!live[i]) continue;
      case (elem_kind[i])
        gpm_pkg::IK_STAR: nxt[i] = 1'b1;
        gpm_pkg::IK_ANY:  nxt[i+1] = 1'b1;
        gpm_pkg::IK_SET:  if (elem_set[i][c]) nxt[i+1] = 1'b1;
        default: if (elem_val[i] == c) nxt[i+1] = 1'b1;
      endcase
    end
    live = close_stars(nxt);
  endfunction

  function automatic void apply_item(gpm_pkg::in_item_t it);
    gpm_pkg::out_item_t r;
    case (it.kind)
      gpm_pkg::KIND_PBYTE: if (it.ch != 0) begin
        if (fresh) begin
          pat_len = 0;
          load_ovf = 1'b0;
          fresh = 1'b0;
        end
        if (pat_len < PMAX) begin
          pat_buf[pat_len] = it.ch;
          pat_len++;
        end else begin
          load_ovf = 1'b1;
        end
      end
      gpm_pkg::KIND_PEND: compile_items();
      gpm_pkg::KIND_TBYTE: if (it.ch != 0) advance_text(it.ch);
      default: begin
        r.matched = !ovf && live[elem_cnt];
        r.pattern_overflow = ovf;
        verdicts.push_back(r);
        live = close_stars(START_POS);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    gpm_pkg::out_item_t e;
    if (!rst_n) begin
      pat_len = 0;
      elem_cnt = 0;
      live = START_POS;
      ovf = 1'b0;
      load_ovf = 1'b0;
      fresh = 1'b1;
      verdicts.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (verdicts.size() == 0) begin
          $error("unexpected result transaction %b", out_data);
          fail_count++;
        end else begin
          e = verdicts.pop_front();
          if (e.matched !== out_data.matched) begin
            $error("matched: expected %b actual %b", e.matched, out_data.matched);
            fail_count++;
          end
          if (e.pattern_overflow !== out_data.pattern_overflow) begin
            $error("pattern_overflow: expected %b actual %b",
                   e.pattern_overflow, out_data.pattern_overflow);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) apply_item(in_data);
    end
    pending = verdicts.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
  end
endmodule

// ===== bench/tb_top.sv =====
// Top of the glob pattern matcher testbench: stimulus, receiver stalls and verdict
module tb_top;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  gpm_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  gpm_pkg::out_item_t out_data;
  int        fail_count;
  int        pending;
  int        cycle = 0;
  logic      send_quiet = 1'b0;
  logic      hold_req = 1'b0;
  int        sent = 0;

  always #5 clk = ~clk;

  glob_pattern_matcher DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  gpm_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > 300000) begin
      $display("FAIL glob_pattern_matcher");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off, one quiet stretch
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold_req && hold == 0) hold = 400;
      if (hold > 0) begin
        hold--;
        if (hold == 0) hold = -1;
        out_ready <= 1'b0;
      end else if (cycle > 4000 && cycle < 6000) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 23);
      end
    end
  end

  task automatic send(logic [1:0] k, logic [7:0] c);
    if (!send_quiet) begin
      while ($urandom_range(99) < 23) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= '{kind: k, ch: c};
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic send_pattern(string s);
    for (int i = 0; i < s.len(); i++) send(gpm_pkg::KIND_PBYTE, s[i]);
    send(gpm_pkg::KIND_PEND, 8'($urandom));
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send(gpm_pkg::KIND_TBYTE, s[i]);
    send(gpm_pkg::KIND_TEND, 8'($urandom));
  endtask

  function automatic logic [7:0] pick_char(bit pat);
    int r;
    string sp;
    sp = "*?[]!^\\-";
    r = $urandom_range(99);
    if (pat && r < 40) return sp[$urandom_range(7)];
    if (!pat && r < 10) return sp[$urandom_range(7)];
    if (r < 88) return 8'h61 + 8'($urandom_range(3));
    return 8'($urandom_range(255, 1));
  endfunction

  initial begin
    int plen, tlen, ntext;
    logic [7:0] c;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_text("");
    send_text("a");
    send_pattern("a*b?");
    send_text("axxbz");
    send_pattern("[!a-c]\\*[]x][a-][z-a]");
    send_text("d*]-");
    send_pattern("[^\\]]?[abcdefghi]");
    send_text("xy");
    send_pattern("[ab\\");
    send_text("[ab\\");
    send(gpm_pkg::KIND_PBYTE, 8'hff);
    send(gpm_pkg::KIND_PBYTE, 8'h01);
    send(gpm_pkg::KIND_PEND, 8'h00);
    send_text("\377\001");
    send_pattern("0123456789abcdefghijklmnopqrstuvwxyz");
    send_text("0");
    send(gpm_pkg::KIND_PEND, 8'hff);
    send_text("");

    while (sent < 1500) begin
      if (sent > 300 && sent < 600) send_quiet <= 1'b1;
      else send_quiet <= 1'b0;
      if (sent > 800) hold_req <= 1'b1;
      if ($urandom_range(9) == 0) begin
        c = 8'($urandom_range(255, 1));
        send(2'($urandom_range(3)), c);
      end else begin
        plen = ($urandom_range(19) == 0) ? $urandom_range(40, 28) : $urandom_range(12);
        for (int i = 0; i < plen; i++) send(gpm_pkg::KIND_PBYTE, pick_char(1'b1));
        send(gpm_pkg::KIND_PEND, 8'($urandom));
        ntext = $urandom_range(6, 1);
        for (int t = 0; t < ntext; t++) begin
          tlen = $urandom_range(10);
          for (int i = 0; i < tlen; i++) send(gpm_pkg::KIND_TBYTE, pick_char(1'b0));
          send(gpm_pkg::KIND_TEND, 8'($urandom));
        end
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS glob_pattern_matcher");
    end else begin
      $display("FAIL glob_pattern_matcher");
    end
    $finish;
  end
endmodule
